// ----- design/siphash_keyed_hash_unit_assert.svh -----
// ----------------------------------------------------------------------------
// SipHash unit assertion macros
// Clocked assertion shorthands for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef SIPHASH_KEYED_HASH_UNIT_ASSERT_SVH
`define SIPHASH_KEYED_HASH_UNIT_ASSERT_SVH

// Clocked assertion, switched off while reset is held.
`define SHK_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define SHK_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- design/shk_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SipHash unit package
// Constants, control word types, microcode table and the SipRound function.
// ----------------------------------------------------------------------------
package shk_pkg;

    localparam logic [63:0] INIT_C0   = 64'h736f6d6570736575;
    localparam logic [63:0] INIT_C1   = 64'h646f72616e646f6d;
    localparam logic [63:0] INIT_C2   = 64'h6c7967656e657261;
    localparam logic [63:0] INIT_C3   = 64'h7465646279746573;
    localparam logic [63:0] FINAL_XOR = 64'h00000000000000ff;

    localparam int unsigned WORD_BYTES = 8;

    // Configuration register indexes
    localparam logic CFG_KEY_LOW  = 1'b0;
    localparam logic CFG_KEY_HIGH = 1'b1;

    // Microcode step addresses
    localparam int unsigned STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_WAIT  = 3'd0;
    localparam logic [STEP_W-1:0] STEP_RND_C = 3'd1;
    localparam logic [STEP_W-1:0] STEP_END_C = 3'd2;
    localparam logic [STEP_W-1:0] STEP_FIN   = 3'd3;
    localparam logic [STEP_W-1:0] STEP_RND_F = 3'd4;
    localparam logic [STEP_W-1:0] STEP_OUT   = 3'd5;
    localparam logic [STEP_W-1:0] STEP_ABS_B = 3'd6;

    typedef logic [3:0][63:0] t_lanes;

    typedef enum logic [2:0] {
        LOP_HOLD,
        LOP_ROUND,
        LOP_ABS_IN,
        LOP_ABS_OUT,
        LOP_FINAL
    } t_lane_op;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_COMP,
        CNT_FINAL,
        CNT_DEC
    } t_cnt_op;

    typedef enum logic [2:0] {
        J_NEXT,
        J_GO,
        J_WAIT_IN,
        J_LOOP,
        J_END,
        J_OUT
    } t_jump;

    typedef struct packed {
        logic              take;
        t_lane_op          lane_op;
        t_cnt_op           cnt_op;
        t_jump             jump;
        logic [STEP_W-1:0] target;
    } t_ctrl;

    // Sequencer to datapath
    typedef struct packed {
        logic     accept;
        t_lane_op lane_op;
        logic     emit;
    } t_dp_ctrl;

    // Datapath to sequencer
    typedef struct packed {
        logic last;
        logic extra;
    } t_dp_status;

    function automatic t_ctrl shk_rom(input logic [STEP_W-1:0] step);
        t_ctrl c;
        c = '{take: 1'b0, lane_op: LOP_HOLD, cnt_op: CNT_HOLD, jump: J_GO,
              target: STEP_WAIT};
        unique case (step)
            STEP_WAIT:  c = '{1'b1, LOP_HOLD,    CNT_COMP,  J_WAIT_IN, STEP_RND_C};
            STEP_RND_C: c = '{1'b0, LOP_ROUND,   CNT_DEC,   J_LOOP,    STEP_RND_C};
            STEP_END_C: c = '{1'b0, LOP_ABS_OUT, CNT_HOLD,  J_END,     STEP_ABS_B};
            STEP_FIN:   c = '{1'b0, LOP_FINAL,   CNT_FINAL, J_NEXT,    STEP_WAIT};
            STEP_RND_F: c = '{1'b0, LOP_ROUND,   CNT_DEC,   J_LOOP,    STEP_RND_F};
            STEP_OUT:   c = '{1'b0, LOP_HOLD,    CNT_HOLD,  J_OUT,     STEP_WAIT};
            STEP_ABS_B: c = '{1'b0, LOP_ABS_IN,  CNT_COMP,  J_GO,      STEP_RND_C};
            default:    c = '{1'b0, LOP_HOLD,    CNT_HOLD,  J_GO,      STEP_WAIT};
        endcase
        return c;
    endfunction

    function automatic logic [63:0] shk_rotl(input logic [63:0] x, input int unsigned r);
        return (x << r) | (x >> (64 - r));
    endfunction

    function automatic t_lanes shk_sip_round(input t_lanes v_in);
        t_lanes v;
        v    = v_in;
        v[0] = v[0] + v[1];
        v[2] = v[2] + v[3];
        v[1] = shk_rotl(v[1], 13) ^ v[0];
        v[3] = shk_rotl(v[3], 16) ^ v[2];
        v[0] = shk_rotl(v[0], 32);
        v[2] = v[2] + v[1];
        v[0] = v[0] + v[3];
        v[1] = shk_rotl(v[1], 17) ^ v[2];
        v[3] = shk_rotl(v[3], 21) ^ v[0];
        v[2] = shk_rotl(v[2], 32);
        return v;
    endfunction

endpackage

// ----- design/siphash_keyed_hash_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SipHash-2-4 keyed hash unit
// Hashes a stream of little-endian 64-bit words under a 128-bit key.
// ----------------------------------------------------------------------------
// Each input transfer carries one message word; the word with i_last_word set
// closes the message and yields one 64-bit hash on the output channel. The key
// (index 0 low half, index 1 high half) is sampled when a message starts, so
// write it only between messages. On each input transfer the word is XORed into
// lane 3; COMPRESS_ROUNDS SipRounds follow and the word is XORed into lane 0,
// after which a non-last word makes the unit ready again. A last word with
// fewer than 8 bytes is followed by the finalisation XOR, FINAL_ROUNDS
// SipRounds and the hand-off of the hash; a last word of 8 bytes first adds one
// more length block with its own COMPRESS_ROUNDS SipRounds. All rounds use the
// single SipRound unit, which runs one round per cycle under the microcode sequencer.
// The result sits in an output register, so the next message may start while
// the hash still waits to be taken; a second hash waits in the sequencer until
// the first has gone.
// ----------------------------------------------------------------------------
module siphash_keyed_hash_unit #(
    parameter int unsigned COMPRESS_ROUNDS = 2,
    parameter int unsigned FINAL_ROUNDS    = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_wdata,
    // message words in
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [63:0] i_message_word,
    input  logic [3:0]  i_byte_count,
    input  logic        i_last_word,
    // hash out
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_hash_value
);

    logic [63:0]          r_key_low;
    logic [63:0]          r_key_high;
    logic                 r_out_valid;
    logic [63:0]          r_hash;
    logic                 w_out_busy;
    logic [63:0]          w_digest;
    shk_pkg::t_dp_ctrl    w_ctrl;
    shk_pkg::t_dp_status  w_status;

    // Key registers: written straight from the configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                shk_pkg::CFG_KEY_LOW:  r_key_low  <= i_cfg_wdata;
                shk_pkg::CFG_KEY_HIGH: r_key_high <= i_cfg_wdata;
                default:               r_key_low  <= r_key_low;
            endcase
        end
    end

    // The output slot is busy while a hash waits and is not taken this cycle
    assign w_out_busy = r_out_valid && !i_out_ready;

    shk_sequencer #(
        .COMPRESS_ROUNDS (COMPRESS_ROUNDS),
        .FINAL_ROUNDS    (FINAL_ROUNDS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_busy (w_out_busy),
        .i_status   (w_status),
        .o_in_ready (o_in_ready),
        .o_ctrl     (w_ctrl)
    );

    shk_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (w_ctrl),
        .i_key_low      (r_key_low),
        .i_key_high     (r_key_high),
        .i_message_word (i_message_word),
        .i_byte_count   (i_byte_count),
        .i_last_word    (i_last_word),
        .o_status       (w_status),
        .o_digest       (w_digest)
    );

    // Output register: load on emit, drop once the transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.emit) begin
            r_hash <= w_digest;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_hash_value = r_hash;

endmodule

// ----- design/shk_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SipHash microcode sequencer
// Step counter, round counter and jump logic over the control word table.
// ----------------------------------------------------------------------------
module shk_sequencer #(
    parameter int unsigned COMPRESS_ROUNDS = 2,
    parameter int unsigned FINAL_ROUNDS    = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_out_busy,
    input  shk_pkg::t_dp_status   i_status,
    output logic                  o_in_ready,
    output shk_pkg::t_dp_ctrl     o_ctrl
);

    localparam int unsigned MAX_ROUNDS =
        (COMPRESS_ROUNDS > FINAL_ROUNDS) ? COMPRESS_ROUNDS : FINAL_ROUNDS;
    localparam int unsigned RCNT_W = $clog2(MAX_ROUNDS + 1);

    logic [shk_pkg::STEP_W-1:0] r_step, n_step;
    logic [RCNT_W-1:0]          r_rcnt, n_rcnt;
    shk_pkg::t_ctrl             w_cw;
    logic                       w_accept;
    logic                       w_emit;
    logic                       w_rnd_done;

    assign w_cw       = shk_pkg::shk_rom(r_step);
    assign w_accept   = w_cw.take && i_in_valid;
    assign w_rnd_done = (r_rcnt == RCNT_W'(1));
    assign w_emit     = (w_cw.jump == shk_pkg::J_OUT) && !i_out_busy;

    assign o_in_ready = w_cw.take;
    assign o_ctrl     = '{accept: w_accept, lane_op: w_cw.lane_op, emit: w_emit};

    always_comb begin
        unique case (w_cw.cnt_op)
            shk_pkg::CNT_HOLD:  n_rcnt = r_rcnt;
            shk_pkg::CNT_COMP:  n_rcnt = RCNT_W'(COMPRESS_ROUNDS);
            shk_pkg::CNT_FINAL: n_rcnt = RCNT_W'(FINAL_ROUNDS);
            shk_pkg::CNT_DEC:   n_rcnt = r_rcnt - RCNT_W'(1);
            default:            n_rcnt = r_rcnt;
        endcase
    end

    always_comb begin
        n_step = r_step + shk_pkg::STEP_W'(1);
        unique case (w_cw.jump)
            shk_pkg::J_NEXT: n_step = r_step + shk_pkg::STEP_W'(1);
            shk_pkg::J_GO:   n_step = w_cw.target;
            shk_pkg::J_WAIT_IN: begin
                n_step = w_accept ? w_cw.target : r_step;
            end
            shk_pkg::J_LOOP: begin
                n_step = w_rnd_done ? r_step + shk_pkg::STEP_W'(1) : w_cw.target;
            end
            shk_pkg::J_END: begin
                priority if (!i_status.last) begin
                    n_step = shk_pkg::STEP_WAIT;
                end else if (i_status.extra) begin
                    n_step = w_cw.target;
                end else begin
                    n_step = r_step + shk_pkg::STEP_W'(1);
                end
            end
            shk_pkg::J_OUT: n_step = i_out_busy ? r_step : w_cw.target;
            default:        n_step = shk_pkg::STEP_WAIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= shk_pkg::STEP_WAIT;
            r_rcnt <= '0;
        end else begin
            r_step <= n_step;
            r_rcnt <= n_rcnt;
        end
    end

endmodule

// ----- design/shk_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SipHash lane datapath
// Four 64-bit lanes, one SipRound per cycle, block and length handling.
// ----------------------------------------------------------------------------
module shk_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  shk_pkg::t_dp_ctrl   i_ctrl,
    input  logic [63:0]         i_key_low,
    input  logic [63:0]         i_key_high,
    input  logic [63:0]         i_message_word,
    input  logic [3:0]          i_byte_count,
    input  logic                i_last_word,
    output shk_pkg::t_dp_status o_status,
    output logic [63:0]         o_digest
);

    shk_pkg::t_lanes r_lanes, n_lanes;
    shk_pkg::t_lanes w_init;
    shk_pkg::t_lanes w_round;
    logic [63:0]     r_cur;
    logic [7:0]      r_len;
    logic            r_mid;
    logic            r_last;
    logic            r_extra;
    logic [3:0]      w_cnt;
    logic [7:0]      w_len_new;
    logic [63:0]     w_masked;
    logic [63:0]     w_block;
    logic            w_full;

    assign w_init = {i_key_high ^ shk_pkg::INIT_C3, i_key_low ^ shk_pkg::INIT_C2,
                     i_key_high ^ shk_pkg::INIT_C1, i_key_low ^ shk_pkg::INIT_C0};
    assign w_round = shk_pkg::shk_sip_round(r_lanes);

    // Byte count: saturate on the last word, count a full word otherwise
    always_comb begin
        if (!i_last_word) begin
            w_cnt = 4'(shk_pkg::WORD_BYTES);
        end else if (i_byte_count > 4'(shk_pkg::WORD_BYTES)) begin
            w_cnt = 4'(shk_pkg::WORD_BYTES);
        end else begin
            w_cnt = i_byte_count;
        end
    end

    assign w_full    = (w_cnt == 4'(shk_pkg::WORD_BYTES));
    assign w_len_new = (r_mid ? r_len : 8'd0) + {4'd0, w_cnt};

    always_comb begin
        w_masked = '0;
        for (int b = 0; b < 8; b++) begin
            if (4'(b) < w_cnt) begin
                w_masked[b*8 +: 8] = i_message_word[b*8 +: 8];
            end
        end
    end

    assign w_block = w_full ? i_message_word : {w_len_new, w_masked[55:0]};

    always_comb begin
        n_lanes = r_lanes;
        if (i_ctrl.accept) begin
            n_lanes    = r_mid ? r_lanes : w_init;
            n_lanes[3] = n_lanes[3] ^ w_block;
        end else begin
            unique case (i_ctrl.lane_op)
                shk_pkg::LOP_HOLD:    n_lanes = r_lanes;
                shk_pkg::LOP_ROUND:   n_lanes = w_round;
                shk_pkg::LOP_ABS_IN:  n_lanes[3] = r_lanes[3] ^ r_cur;
                shk_pkg::LOP_ABS_OUT: n_lanes[0] = r_lanes[0] ^ r_cur;
                shk_pkg::LOP_FINAL:   n_lanes[2] = r_lanes[2] ^ shk_pkg::FINAL_XOR;
                default:              n_lanes = r_lanes;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_lanes <= n_lanes;
        if (i_ctrl.accept) begin
            r_cur <= w_block;
            r_len <= w_len_new;
        end else if (i_ctrl.lane_op == shk_pkg::LOP_ABS_OUT && r_extra) begin
            // queue the length-only block after a full last word
            r_cur <= {r_len, 56'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid   <= 1'b0;
            r_last  <= 1'b0;
            r_extra <= 1'b0;
        end else if (i_ctrl.accept) begin
            r_mid   <= !i_last_word;
            r_last  <= i_last_word;
            r_extra <= i_last_word && w_full;
        end else if (i_ctrl.lane_op == shk_pkg::LOP_ABS_OUT) begin
            r_extra <= 1'b0;
        end
    end

    assign o_status = '{last: r_last, extra: r_extra};
    assign o_digest = r_lanes[0] ^ r_lanes[1] ^ r_lanes[2] ^ r_lanes[3];

endmodule

// ----- design/shk_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SipHash unit port checker
// Port-level checks on the input and output transfers over time.
// ----------------------------------------------------------------------------
`include "siphash_keyed_hash_unit_assert.svh"

module shk_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [63:0] o_hash_value
);

    `SHK_ASSERT_RST(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid, "hash dropped before transfer")
    `SHK_ASSERT_RST(a_out_stable, o_out_valid && !i_out_ready |=> $stable(o_hash_value), "hash changed while stalled")
    `SHK_ASSERT_RST(a_busy_after_in, i_in_valid && o_in_ready |=> !o_in_ready, "word taken without rounds")
    `SHK_ASSERT_ALWAYS(a_no_quick_hash, $rose(o_out_valid) |-> !$past(i_in_valid && o_in_ready), "hash right after a word")

endmodule

bind siphash_keyed_hash_unit shk_checker u_shk_checker (.*);
